/* hw/rtl/sed_pkg.sv */
package sed_pkg;

	// escape phase codes
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_BS    = 3'd1;
	localparam logic [2:0] PH_ZERO1 = 3'd2;
	localparam logic [2:0] PH_ZERO2 = 3'd3;
	localparam logic [2:0] PH_OCT1  = 3'd4;
	localparam logic [2:0] PH_OCT2  = 3'd5;
	localparam logic [2:0] PH_HEX1  = 3'd6;
	localparam logic [2:0] PH_HEX2  = 3'd7;

	localparam logic [7:0] BSLASH   = 8'd92;
	localparam int         MAX_RES  = 3;

	// one group of decoded bytes caused by a single input transfer
	typedef struct packed {
		logic       last;  // input carried the end of the literal
		logic [1:0] cnt;   // number of valid bytes, 1..3
		logic [7:0] b2;
		logic [7:0] b1;
		logic [7:0] b0;
	} sed_grp_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} sed_qstat_t;

endpackage

/* hw/rtl/sed_front.sv */
module sed_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [7:0] in_byte
	input  logic              s_axis_tlast,  // lit_last
	input  sed_pkg::sed_qstat_t q_stat,
	output logic              push,
	output sed_pkg::sed_grp_t grp,
	output logic              idle
);
	import sed_pkg::*;

	logic [2:0] ph_q;
	logic [7:0] d0_q;
	logic [7:0] d1_q;

	logic [2:0] nph;
	logic [7:0] nd0;
	logic [7:0] nd1;
	logic       fire;

	// append one byte to a group, dropping anything past the third
	function automatic sed_grp_t put(sed_grp_t g, logic [7:0] x);
		sed_grp_t r;
		r = g;
		unique case (g.cnt)
			2'd0: r.b0 = x;
			2'd1: r.b1 = x;
			2'd2: r.b2 = x;
			default: ;
		endcase
		if (g.cnt != 2'(MAX_RES)) r.cnt = g.cnt + 2'd1;
		return r;
	endfunction

	function automatic logic is_dig(logic [7:0] x);
		return (x >= "0") && (x <= "9");
	endfunction

	function automatic logic is_hex(logic [7:0] x);
		return is_dig(x) || ((x >= "a") && (x <= "f")) || ((x >= "A") && (x <= "F"));
	endfunction

	// nibble value of a hex digit; letters carry 1..6 in their low nibble
	function automatic logic [3:0] hex_val(logic [7:0] x);
		return is_dig(x) ? x[3:0] : 4'(x[3:0] + 4'd9);
	endfunction

	// two octal-weight digits: a*8 + b
	function automatic logic [7:0] oct2(logic [7:0] a, logic [7:0] b);
		return 8'({a[3:0], 3'b000}) + 8'(b[3:0]);
	endfunction

	assign s_axis_tready = !q_stat.full;
	assign fire          = s_axis_tvalid && s_axis_tready;
	assign idle          = (ph_q == PH_IDLE);

	// classify the byte against the escape phase and build its output group
	always_comb begin
		sed_grp_t    g;
		logic [7:0]  b;
		logic        isd;
		logic        ish;
		logic        do_plain;
		logic [9:0]  v;
		g        = '0;
		b        = s_axis_tdata;
		isd      = is_dig(b);
		ish      = is_hex(b);
		do_plain = 1'b0;
		nph      = ph_q;
		nd0      = d0_q;
		nd1      = d1_q;
		v        = 10'({d0_q[3:0], 6'b000000}) + 10'({d1_q[3:0], 3'b000}) + 10'(b[3:0]);
		unique case (ph_q)
			PH_IDLE: do_plain = 1'b1;
			PH_BS: begin
				nph = PH_IDLE;
				unique case (b)
					"n":  g = put(g, 8'd10);
					"t":  g = put(g, 8'd9);
					"r":  g = put(g, 8'd13);
					"b":  g = put(g, 8'd8);
					"f":  g = put(g, 8'd12);
					"v":  g = put(g, 8'd11);
					"a":  g = put(g, 8'd7);
					"\\": g = put(g, 8'd92);
					"\"": g = put(g, 8'd34);
					"'":  g = put(g, 8'd39);
					"?":  g = put(g, 8'd63);
					"0":  nph = PH_ZERO1;
					"x":  nph = PH_HEX1;
					default: begin
						if ((b >= "1") && (b <= "7")) begin
							nd0 = b;
							nph = PH_OCT1;
						end else begin
							g = put(g, BSLASH);
						end
					end
				endcase
			end
			PH_ZERO1: begin
				if (isd) begin
					nd0 = b;
					nph = PH_ZERO2;
				end else begin
					g        = put(g, 8'd0);
					do_plain = 1'b1;
				end
			end
			PH_ZERO2: begin
				if (isd) begin
					g   = put(g, oct2(d0_q, b));
					nph = PH_IDLE;
				end else begin
					g        = put(g, 8'(d0_q[3:0]));
					do_plain = 1'b1;
				end
			end
			PH_OCT1: begin
				if (isd) begin
					nd1 = b;
					nph = PH_OCT2;
				end else begin
					g        = put(g, 8'(d0_q[3:0]));
					do_plain = 1'b1;
				end
			end
			PH_OCT2: begin
				if (isd) begin
					// above 255: backslash, drop the first digit, pass the rest
					if (v[9:8] == 2'b00) begin
						g = put(g, v[7:0]);
					end else begin
						g = put(g, BSLASH);
						g = put(g, d1_q);
						g = put(g, b);
					end
					nph = PH_IDLE;
				end else begin
					g        = put(g, oct2(d0_q, d1_q));
					do_plain = 1'b1;
				end
			end
			PH_HEX1: begin
				if (ish) begin
					nd0 = b;
					nph = PH_HEX2;
				end else begin
					g        = put(g, BSLASH);
					do_plain = 1'b1;
				end
			end
			PH_HEX2: begin
				if (ish) begin
					g   = put(g, {hex_val(d0_q), hex_val(b)});
					nph = PH_IDLE;
				end else begin
					g        = put(g, BSLASH);
					g        = put(g, d0_q);
					do_plain = 1'b1;
				end
			end
			default: ;
		endcase

		// treat the byte as an ordinary body byte
		if (do_plain) begin
			if (b == BSLASH) begin
				nph = PH_BS;
			end else begin
				nph = PH_IDLE;
				g   = put(g, b);
			end
		end

		// flush whatever escape is still pending at the end of the literal
		if (s_axis_tlast) begin
			unique case (nph)
				PH_BS:    g = put(g, BSLASH);
				PH_ZERO1: g = put(g, 8'd0);
				PH_ZERO2: g = put(g, 8'(nd0[3:0]));
				PH_OCT1:  g = put(g, 8'(nd0[3:0]));
				PH_OCT2:  g = put(g, oct2(nd0, nd1));
				PH_HEX1:  g = put(g, BSLASH);
				PH_HEX2: begin
					g = put(g, BSLASH);
					g = put(g, nd0);
				end
				default: ;
			endcase
			nph = PH_IDLE;
		end
		g.last = s_axis_tlast;
		grp    = g;
	end

	assign push = fire && (grp.cnt != 2'd0);

	// advance the escape phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else if (fire) begin
			ph_q <= nph;
		end
	end

	// hold escape digits
	always_ff @(posedge clk) begin
		if (fire) begin
			d0_q <= nd0;
			d1_q <= nd1;
		end
	end

endmodule

/* hw/rtl/sed_queue.sv */
module sed_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sed_pkg::sed_grp_t   din,
	input  logic                pop,
	output sed_pkg::sed_grp_t   head,
	output sed_pkg::sed_qstat_t stat
);
	import sed_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	sed_grp_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(DEPTH));

	// store pushed groups
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

/* hw/rtl/sed_back.sv */
module sed_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sed_pkg::sed_grp_t   head,
	input  sed_pkg::sed_qstat_t q_stat,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,  // [7:0] out_byte
	output logic                m_axis_tuser,  // run_last
	output logic                m_axis_tlast   // lit_end
);
	import sed_pkg::*;

	logic [1:0] idx_q;
	logic       fire;
	logic       run_last;

	assign m_axis_tvalid = !q_stat.empty;
	assign fire          = m_axis_tvalid && m_axis_tready;
	assign run_last      = (idx_q == head.cnt - 2'd1);
	assign m_axis_tuser  = run_last;
	assign m_axis_tlast  = run_last && head.last;
	assign pop           = fire && run_last;

	// pick the current byte of the head group
	always_comb begin
		unique case (idx_q)
			2'd0:    m_axis_tdata = head.b0;
			2'd1:    m_axis_tdata = head.b1;
			default: m_axis_tdata = head.b2;
		endcase
	end

	// step through the group, restart on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= run_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

/* hw/rtl/string_escape_decoder.sv */
// Decodes the body of a C string literal, one raw byte per input transfer, with
// tlast on the final byte; each decoded byte leaves as one output transfer, tuser
// marking the last byte caused by an input and tlast the last byte of the literal.
// The front end classifies one byte per cycle against the escape phase and pushes
// the decoded bytes it causes, if any, as one group of one to three into a
// QUEUE_DEPTH-entry queue; the back end sends one byte per cycle while the output
// is ready. Input accepts one byte every cycle while the queue is not full,
// and a decoded byte is offered the cycle after its input transfer at the earliest.
module string_escape_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,  // lit_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // run_last
	output logic       m_axis_tlast   // lit_end
);
	import sed_pkg::*;

	sed_grp_t   grp;
	sed_grp_t   head;
	sed_qstat_t q_stat;
	logic       push;
	logic       pop;
	logic       front_idle;

	sed_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_stat        (q_stat),
		.push          (push),
		.grp           (grp),
		.idle          (front_idle)
	);

	sed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (grp),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	sed_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("group pushed into full queue");

	// the queue holds no empty group
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (head.cnt != 2'd0))
		else $error("empty group at queue head");

	// the end of a literal leaves no escape pending
	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> front_idle)
		else $error("escape pending after literal end");

	// the final byte of a literal closes its group
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
		else $error("literal end inside a group");

endmodule
